>>> rtl/bar_pkg.sv
package bar_pkg;

  localparam int BUTTONS = 32;
  localparam int WORD_W  = 32;
  // only the first WORD_W buttons have lanes
  localparam int LANES   = (BUTTONS > WORD_W) ? WORD_W : BUTTONS;

  localparam logic [WORD_W-1:0] LANE_MASK =
    (LANES >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << LANES) - 64'd1);

  localparam int DLY_W     = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = CFG_IDX_W'(1);

  localparam logic [DLY_W-1:0] FIRST_DELAY_RST     = DLY_W'(50);
  localparam logic [DLY_W-1:0] REPEAT_INTERVAL_RST = DLY_W'(10);

  typedef struct packed {
    logic [WORD_W-1:0] held_mask;
    logic [WORD_W-1:0] now_tick;
    logic              ignore_request;
  } poll_t;

  typedef struct packed {
    logic [DLY_W-1:0] first_delay;
    logic [DLY_W-1:0] repeat_interval;
  } cfg_t;

  typedef struct packed {
    logic              upd;
    logic [WORD_W-1:0] now_tick;
    cfg_t              cfg;
  } lane_ctl_t;

endpackage

>>> rtl/bar_channels.sv
interface bar_in_if;
  import bar_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] held_mask;
  logic [WORD_W-1:0] now_tick;
  logic              ignore_request;

  modport source (output valid, held_mask, now_tick, ignore_request, input ready);
  modport sink   (input valid, held_mask, now_tick, ignore_request, output ready);
endinterface

interface bar_out_if;
  import bar_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] held_out;
  logic [WORD_W-1:0] repeat_out;
  logic              ignoring;

  modport source (output valid, held_out, repeat_out, ignoring, input ready);
  modport sink   (input valid, held_out, repeat_out, ignoring, output ready);
endinterface

interface bar_cfg_if;
  import bar_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DLY_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/button_autorepeat_core.sv
// An accepted poll beat passes the input register, then per-button compare/add
//   into the result register, which presents its result beat.
// Throughput: one poll per cycle when not stalled; all 32 lanes update together.
// Reset: synchronous, active low; clears button state, ignore flag and valid bits,
//   and loads first_delay = 50, repeat_interval = 10. No ready during reset.
module button_autorepeat_core (
  input  logic      clk,
  input  logic      rst_n,
  bar_in_if.sink    in_bus,
  bar_out_if.source out_bus,
  bar_cfg_if.sink   cfg_bus
);
  import bar_pkg::*;

  cfg_t              cfg;
  lane_ctl_t         lane_ctl;
  logic              s1_valid_r, s1_valid_nxt;
  poll_t             s1_r;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] held_out_r, repeat_out_r;
  logic              ignoring_r;
  logic              ignore_flag_r;
  logic              in_acc, adv, ign;
  logic [WORD_W-1:0] held, rep;

  bar_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  assign adv           = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready  = rst_n && (!s1_valid_r || adv);
  assign in_acc        = in_bus.valid && in_bus.ready;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_bus.ready);

  assign held = s1_r.held_mask & LANE_MASK;
  assign ign  = ignore_flag_r || s1_r.ignore_request;

  assign lane_ctl.upd      = adv;
  assign lane_ctl.now_tick = s1_r.now_tick;
  assign lane_ctl.cfg      = cfg;

  for (genvar i = 0; i < WORD_W; i++) begin : g_lane
    if (i < LANES) begin : g_on
      bar_lane u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (lane_ctl),
        .held  (held[i]),
        .rep   (rep[i])
      );
    end else begin : g_off
      assign rep[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      ignore_flag_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        // flag drops on the first poll with nothing held
        ignore_flag_r <= ign && (held != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.held_mask      <= in_bus.held_mask;
      s1_r.now_tick       <= in_bus.now_tick;
      s1_r.ignore_request <= in_bus.ignore_request;
    end
    if (adv) begin
      held_out_r   <= ign ? '0 : held;
      repeat_out_r <= ign ? '0 : rep;
      ignoring_r   <= ign;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.held_out   = held_out_r;
  assign out_bus.repeat_out = repeat_out_r;
  assign out_bus.ignoring   = ignoring_r;

endmodule

>>> rtl/bar_cfg_regs.sv
module bar_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  bar_cfg_if.sink       cfg_bus,
  output bar_pkg::cfg_t cfg
);
  import bar_pkg::*;

  logic [DLY_W-1:0] first_delay_r, first_delay_nxt;
  logic [DLY_W-1:0] repeat_interval_r, repeat_interval_nxt;

  assign cfg_bus.ready = rst_n;

  always_comb begin
    first_delay_nxt     = first_delay_r;
    repeat_interval_nxt = repeat_interval_r;
    if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        CFG_FIRST_DELAY:     first_delay_nxt     = cfg_bus.data;
        CFG_REPEAT_INTERVAL: repeat_interval_nxt = cfg_bus.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_delay_r     <= FIRST_DELAY_RST;
      repeat_interval_r <= REPEAT_INTERVAL_RST;
    end else begin
      first_delay_r     <= first_delay_nxt;
      repeat_interval_r <= repeat_interval_nxt;
    end
  end

  assign cfg.first_delay     = first_delay_r;
  assign cfg.repeat_interval = repeat_interval_r;

endmodule

>>> rtl/bar_lane.sv
module bar_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  bar_pkg::lane_ctl_t ctl,
  input  logic               held,
  output logic               rep
);
  import bar_pkg::*;

  logic              first_seen_r, first_seen_nxt;
  logic [WORD_W-1:0] deadline_r, deadline_nxt;
  logic [WORD_W-1:0] diff;
  logic              passed;

  // wrapped compare: passed when now is strictly ahead, by less than half the range
  assign diff   = ctl.now_tick - deadline_r;
  assign passed = (diff != '0) && !diff[WORD_W-1];

  always_comb begin
    first_seen_nxt = first_seen_r;
    deadline_nxt   = deadline_r;
    rep            = 1'b0;
    if (held) begin
      if (first_seen_r) begin
        if (passed) begin
          rep          = 1'b1;
          deadline_nxt = ctl.now_tick + WORD_W'(ctl.cfg.repeat_interval);
        end
      end else begin
        first_seen_nxt = 1'b1;
        rep            = 1'b1;
        deadline_nxt   = ctl.now_tick + WORD_W'(ctl.cfg.first_delay);
      end
    end else begin
      first_seen_nxt = 1'b0;
      deadline_nxt   = ctl.now_tick - WORD_W'(ctl.cfg.repeat_interval);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_seen_r <= 1'b0;
    end else if (ctl.upd) begin
      first_seen_r <= first_seen_nxt;
    end
  end

  // deadline is only consulted once first_seen is set, which also loads it
  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      deadline_r <= deadline_nxt;
    end
  end

endmodule

>>> rtl/bar_checker.sv
module bar_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bar_pkg::WORD_W-1:0] held_out,
  input logic [bar_pkg::WORD_W-1:0] repeat_out,
  input logic                      ignoring
);
  import bar_pkg::*;

  a_ignore_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ignoring |-> (held_out == '0) && (repeat_out == '0))
    else $error("result beat shows buttons while ignoring");

  a_repeat_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (repeat_out & ~held_out) == '0)
    else $error("repeat pulse on a button that is not held");

  a_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((held_out | repeat_out) & ~LANE_MASK) == '0)
    else $error("bits beyond the button range in a result beat");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(held_out) &&
      $stable(repeat_out) && $stable(ignoring))
    else $error("stalled result beat changed");

endmodule

bind button_autorepeat_core bar_checker u_bar_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .held_out   (out_bus.held_out),
  .repeat_out (out_bus.repeat_out),
  .ignoring   (out_bus.ignoring)
);

>>> dv/tb_button_autorepeat_core.sv
`timescale 1ns / 100ps

module tb_button_autorepeat_core;
  import bar_pkg::*;

  localparam int WD_LIMIT  = 4000;
  localparam int STALL_LEN = 300;
  localparam int DRAIN_CYC = 4;
  localparam int PHASE_N   = 190;

  typedef struct packed {
    logic [WORD_W-1:0] held_out;
    logic [WORD_W-1:0] repeat_out;
    logic              ignoring;
  } report_t;

  typedef struct packed {
    poll_t   p;
    logic    pinned;
    report_t r;
  } row_t;

  logic clk;
  logic rst_n;

  bar_in_if  in_if();
  bar_out_if out_if();
  bar_cfg_if cfg_if();

  button_autorepeat_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predictor state
  logic [DLY_W-1:0]  dly_first;
  logic [DLY_W-1:0]  dly_repeat;
  logic [WORD_W-1:0] seen_mask;
  logic [WORD_W-1:0] pulse_mask;
  logic [WORD_W-1:0] due_at [LANES];
  logic              mute;

  report_t pending_reports [$];

  // side info travelling with the presented poll beat
  logic    pin_on;
  report_t pin_rpt;

  logic              no_idle;
  logic              hold_used;
  int                stall_left;
  int                err_cnt;
  int                n_checked;
  int                n_directed;
  int                n_random;
  int                n_settings;
  int                idle_cycles;
  logic [WORD_W-1:0] rand_mask;
  logic [WORD_W-1:0] rand_tick;
  row_t              dir_tab [$];

  function automatic report_t typematic_step(input poll_t p);
    logic [WORD_W-1:0] held;
    logic [WORD_W-1:0] now;
    logic [WORD_W-1:0] diff;
    report_t           r;
    int                i;
    held = p.held_mask & LANE_MASK;
    now  = p.now_tick;
    if (p.ignore_request) mute = 1'b1;
    for (i = 0; i < LANES; i++) begin
      if (held[i]) begin
        if (seen_mask[i]) begin
          diff = now - due_at[i];
          // wrap-aware: passed when difference is positive as a signed word
          if (diff != '0 && !diff[WORD_W-1]) begin
            pulse_mask[i] = 1'b1;
            due_at[i]     = now + WORD_W'(dly_repeat);
          end else begin
            pulse_mask[i] = 1'b0;
          end
        end else begin
          seen_mask[i]  = 1'b1;
          pulse_mask[i] = 1'b1;
          due_at[i]     = now + WORD_W'(dly_first);
        end
      end else begin
        due_at[i]     = now - WORD_W'(dly_repeat);
        pulse_mask[i] = 1'b0;
        seen_mask[i]  = 1'b0;
      end
    end
    r.ignoring = mute;
    if (mute) begin
      if (held == '0) mute = 1'b0;
      held       = '0;
      pulse_mask = '0;
    end
    r.held_out   = held;
    r.repeat_out = pulse_mask;
    return r;
  endfunction

  // all beats are observed here: results first, then polls, then register writes
  always @(posedge clk) begin
    report_t want;
    report_t got;
    report_t calc;
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.held_out, out_if.repeat_out, out_if.ignoring};
        if (pending_reports.size() == 0) begin
          $error("result beat with nothing pending: held_out %h repeat_out %h ignoring %b",
                 got.held_out, got.repeat_out, got.ignoring);
          err_cnt++;
        end else begin
          want = pending_reports.pop_front();
          if (got.held_out !== want.held_out) begin
            $error("held_out: expected %h, got %h", want.held_out, got.held_out);
            err_cnt++;
          end
          if (got.repeat_out !== want.repeat_out) begin
            $error("repeat_out: expected %h, got %h", want.repeat_out, got.repeat_out);
            err_cnt++;
          end
          if (got.ignoring !== want.ignoring) begin
            $error("ignoring: expected %b, got %b", want.ignoring, got.ignoring);
            err_cnt++;
          end
        end
        n_checked++;
      end
      if (in_if.valid && in_if.ready) begin
        calc = typematic_step('{in_if.held_mask, in_if.now_tick, in_if.ignore_request});
        pending_reports.push_back(pin_on ? pin_rpt : calc);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_FIRST_DELAY:     dly_first  = cfg_if.data;
          CFG_REPEAT_INTERVAL: dly_repeat = cfg_if.data;
          default: ;
        endcase
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // result side: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (!hold_used && n_checked >= 500) begin
      hold_used  = 1'b1;
      stall_left = STALL_LEN;
    end
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if (!no_idle && $urandom_range(0, 99) < 35) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_poll(input poll_t p, input logic pinned, input report_t r);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 35) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.held_mask      <= p.held_mask;
    in_if.now_tick       <= p.now_tick;
    in_if.ignore_request <= p.ignore_request;
    pin_on               <= pinned;
    pin_rpt              <= r;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DLY_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic new_setting(input logic [DLY_W-1:0] first, input logic [DLY_W-1:0] rep);
    quiesce();
    cfg_write(CFG_FIRST_DELAY, first);
    cfg_write(CFG_REPEAT_INTERVAL, rep);
    n_settings++;
  endtask

  function automatic row_t row(input logic [WORD_W-1:0] held, input logic [WORD_W-1:0] now,
                               input logic ign, input logic pinned,
                               input logic [WORD_W-1:0] e_held,
                               input logic [WORD_W-1:0] e_rep, input logic e_ign);
    row_t t;
    t.p      = '{held, now, ign};
    t.pinned = pinned;
    t.r      = '{e_held, e_rep, e_ign};
    return t;
  endfunction

  // mostly plausible button activity on a moving tick, some noise
  task automatic run_random(input int count);
    int unsigned pick;
    int unsigned step;
    int unsigned bitpos;
    poll_t       p;
    report_t     none;
    none = '0;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        rand_mask = $urandom();
      end else if (pick < 14) begin
        rand_mask = '0;
      end else if (pick < 17) begin
        rand_mask = '1;
      end else if (pick >= 55) begin
        bitpos = $urandom_range(0, WORD_W - 1);
        rand_mask[bitpos] = ~rand_mask[bitpos];
        if (pick >= 85) begin
          bitpos = $urandom_range(0, WORD_W - 1);
          rand_mask[bitpos] = ~rand_mask[bitpos];
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        rand_tick = $urandom();
      end else begin
        if (pick < 15)
          step = 0;
        else if (pick < 65)
          step = $urandom_range(0, int'(dly_repeat) + 2);
        else if (pick < 90)
          step = $urandom_range(0, int'(dly_first) + 2);
        else
          step = $urandom_range(0, 2 * (int'(dly_first) + int'(dly_repeat)) + 4);
        rand_tick = rand_tick + step;
      end
      p.held_mask      = rand_mask;
      p.now_tick       = rand_tick;
      p.ignore_request = ($urandom_range(0, 99) < 5);
      send_poll(p, 1'b0, none);
      n_random++;
    end
  endtask

  initial begin
    int k;
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.held_mask      = '0;
    in_if.now_tick       = '0;
    in_if.ignore_request = 1'b0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    pin_on               = 1'b0;
    pin_rpt              = '0;
    no_idle              = 1'b0;
    hold_used            = 1'b0;
    stall_left           = 0;
    err_cnt              = 0;
    n_checked            = 0;
    n_directed           = 0;
    n_random             = 0;
    n_settings           = 1;
    idle_cycles          = 0;
    rand_mask            = '0;
    rand_tick            = '0;
    dly_first            = FIRST_DELAY_RST;
    dly_repeat           = REPEAT_INTERVAL_RST;
    seen_mask            = '0;
    pulse_mask           = '0;
    mute                 = 1'b0;
    for (k = 0; k < LANES; k++) due_at[k] = '0;

    // reset delays 50 / 10
    dir_tab.push_back(row(32'h0000_0000, 32'd0,   1'b0, 1'b1, 32'h0, 32'h0, 1'b0));
    dir_tab.push_back(row(32'hFFFF_FFFF, 32'd100, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    // deadline equal to now is not yet due
    dir_tab.push_back(row(32'hFFFF_FFFF, 32'd150, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'h0, 1'b0));
    dir_tab.push_back(row(32'hFFFF_FFFF, 32'd151, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    dir_tab.push_back(row(32'hFFFF_FFFF, 32'd161, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'h0, 1'b0));
    dir_tab.push_back(row(32'hFFFF_FFFF, 32'd162, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    dir_tab.push_back(row(32'h0000_0001, 32'd163, 1'b0, 1'b1, 32'h1, 32'h0, 1'b0));
    // ignore with a button down sticks until all are released
    dir_tab.push_back(row(32'h0000_0001, 32'd164, 1'b1, 1'b1, 32'h0, 32'h0, 1'b1));
    dir_tab.push_back(row(32'h0000_0001, 32'd200, 1'b0, 1'b1, 32'h0, 32'h0, 1'b1));
    dir_tab.push_back(row(32'h0000_0000, 32'd201, 1'b0, 1'b1, 32'h0, 32'h0, 1'b1));
    dir_tab.push_back(row(32'h8000_0000, 32'd202, 1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000, 1'b0));
    // half-range apart: not passed; one less: passed
    dir_tab.push_back(row(32'h8000_0000, 32'h8000_00FC, 1'b0, 1'b1, 32'h8000_0000, 32'h0, 1'b0));
    dir_tab.push_back(row(32'h8000_0000, 32'h8000_00FB, 1'b0, 1'b1,
                          32'h8000_0000, 32'h8000_0000, 1'b0));
    // ignore with nothing held clears on the same poll
    dir_tab.push_back(row(32'h0000_0000, 32'h8000_0200, 1'b1, 1'b1, 32'h0, 32'h0, 1'b1));
    dir_tab.push_back(row(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0, 32'h0, 1'b0));
    // deadline wraps past zero
    dir_tab.push_back(row(32'h5555_5555, 32'hFFFF_FFF0, 1'b0, 1'b1,
                          32'h5555_5555, 32'h5555_5555, 1'b0));
    dir_tab.push_back(row(32'h5555_5555, 32'h0000_0022, 1'b0, 1'b1, 32'h5555_5555, 32'h0, 1'b0));
    dir_tab.push_back(row(32'h5555_5555, 32'h0000_0023, 1'b0, 1'b1,
                          32'h5555_5555, 32'h5555_5555, 1'b0));
    dir_tab.push_back(row(32'hAAAA_AAAA, 32'h0000_0024, 1'b0, 1'b1,
                          32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0));
    dir_tab.push_back(row(32'hFFFF_FFFF, 32'h0000_0030, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0));
    dir_tab.push_back(row(32'hFFFF_FFFF, 32'h0000_0057, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0));
    dir_tab.push_back(row(32'h0000_FFFF, 32'h0000_0060, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0));
    dir_tab.push_back(row(32'hFFFF_0000, 32'h0000_0061, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0));
    dir_tab.push_back(row(32'h0000_0000, 32'h0000_0062, 1'b0, 1'b1, 32'h0, 32'h0, 1'b1));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      send_poll(dir_tab[i].p, dir_tab[i].pinned, dir_tab[i].r);
      n_directed++;
    end
    rand_tick = 32'h0000_1000;

    run_random(PHASE_N);
    new_setting(16'd1, 16'd1);
    run_random(PHASE_N);
    new_setting(16'hFFFF, 16'hFFFF);
    run_random(PHASE_N);
    // zero delays, and no idling on either side for this stretch
    new_setting(16'd0, 16'd0);
    no_idle = 1'b1;
    run_random(PHASE_N);
    no_idle = 1'b0;
    new_setting(16'd1, 16'hFFFF);
    run_random(PHASE_N);
    new_setting(16'hFFFF, 16'd1);
    run_random(PHASE_N);
    new_setting(DLY_W'($urandom_range(1, 300)), DLY_W'($urandom_range(1, 60)));
    run_random(PHASE_N);

    quiesce();
    $display("covered %0d directed and %0d random polls under %0d delay settings",
             n_directed, n_random, n_settings);
    $display("%0d results compared, %0d mismatches, one long result-side hold-off",
             n_checked, err_cnt);
    if (err_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
rtl/bar_pkg.sv
rtl/bar_channels.sv
rtl/bar_cfg_regs.sv
rtl/bar_lane.sv
rtl/button_autorepeat_core.sv
rtl/bar_checker.sv
dv/tb_button_autorepeat_core.sv
